// File: rtl/u8u16_pkg.sv
// u8u16_pkg: shared constants, result word types and helpers for the UTF-8 to UTF-16 converter.
// No dependencies; compiled first.
package u8u16_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int SHOWN_WIDTH     = 24;
    localparam int MAX_RESULTS     = 3;

    // byte classes
    localparam logic [7:0] CONT_BASE = 8'h80;
    localparam logic [7:0] LEAD_1    = 8'hC0;
    localparam logic [7:0] LEAD_2    = 8'hE0;
    localparam logic [7:0] LEAD_3    = 8'hF0;
    localparam logic [7:0] LEAD_4    = 8'hF8;
    localparam logic [7:0] LEAD_5    = 8'hFC;

    // value ranges
    localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
    localparam logic [31:0] VALUE_END  = 32'h0011_0000;
    localparam logic [15:0] HI_SUR     = 16'hD800;
    localparam logic [15:0] LO_SUR     = 16'hDC00;
    localparam logic [23:0] SHOWN_MAX  = 24'hFF_FFFF;

    typedef struct packed {
        logic [15:0]            unit;
        logic                   is_terminator;
        logic [SHOWN_WIDTH-1:0] unit_count;
        logic                   last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]                    num;   // 0..3 words
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    // count as seen on the port, clipped to 24 bits
    function automatic logic [SHOWN_WIDTH-1:0] show_count(input logic [31:0] c);
        logic [SHOWN_WIDTH-1:0] r;
        if (c > 32'(SHOWN_MAX)) begin
            r = SHOWN_MAX;
        end else begin
            r = c[SHOWN_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/u8u16_in_if.sv
// u8u16_in_if: byte channel into the converter (valid/ready plus payload).
// Depends on nothing.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// File: rtl/u8u16_out_if.sv
// u8u16_out_if: UTF-16 word channel out of the converter (valid/ready plus payload).
// Depends on nothing.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit;
    logic        is_terminator;
    logic [23:0] unit_count;
    logic        last_of_run;

    modport source (output valid, output unit, output is_terminator, output unit_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input unit, input is_terminator, input unit_count,
                    input last_of_run, output ready);
endinterface

// File: rtl/utf8_to_utf16_converter.sv
// utf8_to_utf16_converter: top level - input register, decoder state and result register.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_decode and u8u16_out.
//
// Takes one UTF-8 byte per word on i_in and sends UTF-16 code units on o_out, each with a
// running unit count, plus a zero terminator word after the byte flagged end_of_string.
// Timing: a byte is held in the input register, is decoded in one pass and is loaded into
// the result register once that register is free; its words are then offered in order.
// A byte that yields at most one word lets the next byte in every cycle while the receiver
// takes each word as offered; a byte that yields k words (surrogate pair and/or terminator,
// k up to 3) holds the result register until all k are taken, and input waits until
// the last one is taken. Bytes that yield no word (lead and continuation bytes mid-sequence,
// ignored bytes after a halt) pass at one per cycle if the output is free. Sequences may be
// up to six bytes long (lead ranges C0, E0, F0, F8, FC); a stray continuation byte or a value
// at or past 0x110000 mutes the rest of the string, but the terminator still follows.
// COUNT_WIDTH sets the width of the internal unit counter, which saturates; the reported
// count is further clipped to 24 bits. All decoder state clears after each terminator.
module utf8_to_utf16_converter #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eos;

    // decoder state
    logic [2:0]             r_pend;
    logic [31:0]            r_code;
    logic                   r_halt;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [2:0]             n_pend;
    logic [31:0]            n_code;
    logic                   n_halt;
    logic [COUNT_WIDTH-1:0] n_count;

    u8u16_pkg::t_bundle bundle;
    logic               out_free;
    logic               advance;

    // byte moves on once the result register is empty or drains its last word now
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_eos  <= i_in.end_of_string;
        end
    end

    u8u16_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_byte   (r_byte),
        .i_eos    (r_eos),
        .i_pend   (r_pend),
        .i_code   (r_code),
        .i_halt   (r_halt),
        .i_count  (r_count),
        .o_pend   (n_pend),
        .o_code   (n_code),
        .o_halt   (n_halt),
        .o_count  (n_count),
        .o_bundle (bundle)
    );

    // state follows each decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 3'd0;
            r_code  <= 32'd0;
            r_halt  <= 1'b0;
            r_count <= '0;
        end else if (advance) begin
            r_pend  <= n_pend;
            r_code  <= n_code;
            r_halt  <= n_halt;
            r_count <= n_count;
        end
    end

    u8u16_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && (bundle.num != 2'd0)),
        .i_bundle (bundle),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

// File: rtl/u8u16_decode.sv
// u8u16_decode: combinational step for one byte - next decoder state and up to three words.
// Depends on u8u16_pkg.
module u8u16_decode #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic [7:0]             i_byte,
    input  logic                   i_eos,
    input  logic [2:0]             i_pend,
    input  logic [31:0]            i_code,
    input  logic                   i_halt,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic [2:0]             o_pend,
    output logic [31:0]            o_code,
    output logic                   o_halt,
    output logic [COUNT_WIDTH-1:0] o_count,
    output u8u16_pkg::t_bundle     o_bundle
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic        emit;
    logic [31:0] val;
    logic [7:0]  base;
    logic [2:0]  len;
    logic [2:0]  pend_dec;
    logic [19:0] sup;
    logic [1:0]  units;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic [COUNT_WIDTH-1:0] cnt_a;
    logic [COUNT_WIDTH-1:0] cnt_b;
    logic [COUNT_WIDTH-1:0] cnt_end;
    logic        halt_v;
    logic        halt_s;
    logic [2:0]  pend_s;
    logic [31:0] code_s;

    // lead byte class
    always_comb begin
        if (i_byte >= u8u16_pkg::LEAD_5) begin
            base = u8u16_pkg::LEAD_5; len = 3'd5;
        end else if (i_byte >= u8u16_pkg::LEAD_4) begin
            base = u8u16_pkg::LEAD_4; len = 3'd4;
        end else if (i_byte >= u8u16_pkg::LEAD_3) begin
            base = u8u16_pkg::LEAD_3; len = 3'd3;
        end else if (i_byte >= u8u16_pkg::LEAD_2) begin
            base = u8u16_pkg::LEAD_2; len = 3'd2;
        end else begin
            base = u8u16_pkg::LEAD_1; len = 3'd1;
        end
    end

    assign pend_dec = i_pend - 3'd1;

    // sequence tracking
    always_comb begin
        emit   = 1'b0;
        val    = i_code;
        halt_s = i_halt;
        pend_s = i_pend;
        code_s = i_code;
        if (!i_halt) begin
            if (i_pend == 3'd0) begin
                if (i_byte < u8u16_pkg::CONT_BASE) begin
                    emit = 1'b1;
                    val  = 32'(i_byte);
                end else if (i_byte < u8u16_pkg::LEAD_1) begin
                    halt_s = 1'b1;             // stray continuation
                end else begin
                    code_s = 32'(i_byte - base);
                    pend_s = len;
                    val    = 32'(i_byte - base);
                    if (i_eos) begin
                        pend_s = 3'd0;
                        emit   = 1'b1;
                    end
                end
            end else begin
                if (i_byte[7:6] == 2'b10) begin
                    code_s = {i_code[25:0], i_byte[5:0]};
                    val    = {i_code[25:0], i_byte[5:0]};
                    pend_s = pend_dec;
                    if (pend_dec == 3'd0 || i_eos) begin
                        pend_s = 3'd0;
                        emit   = 1'b1;
                    end
                end else begin
                    // broken sequence: byte eaten, partial value goes out
                    pend_s = 3'd0;
                    emit   = 1'b1;
                end
            end
        end
    end

    // value to words
    assign sup = 20'(val - u8u16_pkg::SUPP_BASE);

    always_comb begin
        units  = 2'd0;
        halt_v = 1'b0;
        unit_a = val[15:0];
        unit_b = u8u16_pkg::LO_SUR + 16'(sup[9:0]);
        if (emit) begin
            if (val < u8u16_pkg::SUPP_BASE) begin
                units = 2'd1;
            end else if (val >= u8u16_pkg::VALUE_END) begin
                halt_v = 1'b1;
            end else begin
                units  = 2'd2;
                unit_a = u8u16_pkg::HI_SUR + 16'(sup[19:10]);
            end
        end
    end

    // saturating counts after each word
    assign cnt_a = (i_count == CNT_MAX) ? i_count : i_count + COUNT_WIDTH'(1);
    assign cnt_b = (cnt_a == CNT_MAX) ? cnt_a : cnt_a + COUNT_WIDTH'(1);

    always_comb begin
        case (units)
            2'd0:    cnt_end = i_count;
            2'd1:    cnt_end = cnt_a;
            default: cnt_end = cnt_b;
        endcase
    end

    // word bundle
    always_comb begin
        o_bundle.num = units + 2'(i_eos);

        o_bundle.res[0].unit          = (units != 2'd0) ? unit_a : 16'd0;
        o_bundle.res[0].is_terminator = (units == 2'd0);
        o_bundle.res[0].unit_count    = u8u16_pkg::show_count(32'((units != 2'd0) ? cnt_a
                                                                                  : i_count));
        o_bundle.res[1].unit          = (units == 2'd2) ? unit_b : 16'd0;
        o_bundle.res[1].is_terminator = (units != 2'd2);
        o_bundle.res[1].unit_count    = u8u16_pkg::show_count(32'((units == 2'd2) ? cnt_b
                                                                                  : cnt_end));
        o_bundle.res[2].unit          = 16'd0;
        o_bundle.res[2].is_terminator = 1'b1;
        o_bundle.res[2].unit_count    = u8u16_pkg::show_count(32'(cnt_end));

        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++) begin
            o_bundle.res[i].last_of_run = ((2'(i) + 2'd1) == o_bundle.num);
        end
    end

    // state after the byte; string end clears everything
    always_comb begin
        if (i_eos) begin
            o_pend  = 3'd0;
            o_code  = 32'd0;
            o_halt  = 1'b0;
            o_count = '0;
        end else begin
            o_pend  = pend_s;
            o_code  = code_s;
            o_halt  = halt_s | halt_v;
            o_count = cnt_end;
        end
    end

endmodule

// File: rtl/u8u16_out.sv
// u8u16_out: result register for one byte's words, sent one per cycle while ready.
// Depends on u8u16_pkg and u8u16_out_if.
module u8u16_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  u8u16_pkg::t_bundle i_bundle,
    output logic               o_free,
    u8u16_out_if.source        o_out
);

    logic               r_valid;
    logic [1:0]         r_idx;
    u8u16_pkg::t_bundle r_bundle;
    u8u16_pkg::t_result cur;
    logic               pop;
    logic               last_pop;

    assign cur      = r_bundle.res[r_idx];
    assign pop      = r_valid && o_out.ready;
    assign last_pop = pop && ((r_idx + 2'd1) == r_bundle.num);
    assign o_free   = !r_valid || last_pop;

    assign o_out.valid         = r_valid;
    assign o_out.unit          = cur.unit;
    assign o_out.is_terminator = cur.is_terminator;
    assign o_out.unit_count    = cur.unit_count;
    assign o_out.last_of_run   = cur.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (last_pop) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (pop) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

// File: dv/tb_utf8_to_utf16_converter.sv
// Self-checking bench for utf8_to_utf16_converter: directed and random UTF-8 strings in,
// every UTF-16 word out compared against an in-bench decoder model.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if and the converter RTL.
module tb_utf8_to_utf16_converter;

    localparam int COUNT_W     = u8u16_pkg::COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 64;
    localparam int RAND_BYTES  = 150;

    // ------------------------------------------------------------------
    // Decoder model plus queue of words still due from the block
    // ------------------------------------------------------------------
    class utf16_scoreboard;
        logic [2:0]         cont_left;  // continuation bytes still to come
        logic [31:0]        acc;        // code point being assembled
        bit                 muted;      // string muted until its last byte
        logic [COUNT_W-1:0] units;      // units emitted so far, saturating
        u8u16_pkg::t_result run_q[$];   // words caused by the current byte
        u8u16_pkg::t_result due_q[$];   // words not yet seen on o_out
        int                 errors;

        function new();
            clear_string();
            errors = 0;
        endfunction

        function void clear_string();
            cont_left = '0;
            acc       = '0;
            muted     = 1'b0;
            units     = '0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void put_word(logic [15:0] u, logic term);
            u8u16_pkg::t_result w;
            w.unit          = u;
            w.is_terminator = term;
            w.unit_count    = u8u16_pkg::show_count(32'(units));
            w.last_of_run   = 1'b0;
            run_q.push_back(w);
        endfunction

        function void put_unit(logic [15:0] u);
            if (units != '1) begin
                units++;
            end
            put_word(u, 1'b0);
        endfunction

        // finished (or cut short) sequence: one unit, a surrogate pair, or mute
        function void put_code(logic [31:0] v);
            logic [31:0] off;
            if (v < u8u16_pkg::SUPP_BASE) begin
                put_unit(v[15:0]);
            end else begin
                off = v - u8u16_pkg::SUPP_BASE;
                if (off >= u8u16_pkg::VALUE_END - u8u16_pkg::SUPP_BASE) begin
                    muted = 1'b1;
                end else begin
                    put_unit(u8u16_pkg::HI_SUR + 16'(off[19:10]));
                    put_unit(u8u16_pkg::LO_SUR + 16'(off[9:0]));
                end
            end
        endfunction

        // Accepted input word; returns 1 unless the string was already muted.
        function bit note_byte(logic [7:0] b, logic eos);
            bit live;
            live = !muted;
            run_q.delete();
            if (!muted) begin
                if (cont_left == 0) begin
                    if (b < u8u16_pkg::CONT_BASE) begin
                        put_unit({8'h00, b});
                    end else if (b < u8u16_pkg::LEAD_1) begin
                        muted = 1'b1;                       // stray continuation
                    end else begin
                        if (b < u8u16_pkg::LEAD_2) begin
                            acc = 32'(b - u8u16_pkg::LEAD_1); cont_left = 3'd1;
                        end else if (b < u8u16_pkg::LEAD_3) begin
                            acc = 32'(b - u8u16_pkg::LEAD_2); cont_left = 3'd2;
                        end else if (b < u8u16_pkg::LEAD_4) begin
                            acc = 32'(b - u8u16_pkg::LEAD_3); cont_left = 3'd3;
                        end else if (b < u8u16_pkg::LEAD_5) begin
                            acc = 32'(b - u8u16_pkg::LEAD_4); cont_left = 3'd4;
                        end else begin
                            acc = 32'(b - u8u16_pkg::LEAD_5); cont_left = 3'd5;
                        end
                        if (eos) begin
                            cont_left = '0;
                            put_code(acc);
                        end
                    end
                end else if (b >= u8u16_pkg::CONT_BASE && b < u8u16_pkg::LEAD_1) begin
                    acc = {acc[25:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0 || eos) begin
                        cont_left = '0;
                        put_code(acc);
                    end
                end else begin
                    // broken sequence: byte swallowed, partial value goes out
                    cont_left = '0;
                    put_code(acc);
                end
            end
            if (eos) begin
                put_word(16'h0000, 1'b1);
                clear_string();
            end
            if (run_q.size() > 0) begin
                run_q[run_q.size()-1].last_of_run = 1'b1;
            end
            foreach (run_q[k]) begin
                due_q.push_back(run_q[k]);
            end
            return live;
        endfunction

        task check_word(u8u16_pkg::t_result got);
            u8u16_pkg::t_result want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word unit=%h term=%0d", got.unit,
                                 got.is_terminator));
                return;
            end
            want = due_q.pop_front();
            if (got.unit !== want.unit)
                report($sformatf("unit got %h want %h", got.unit, want.unit));
            if (got.is_terminator !== want.is_terminator)
                report($sformatf("is_terminator got %0d want %0d",
                                 got.is_terminator, want.is_terminator));
            if (got.unit_count !== want.unit_count)
                report($sformatf("unit_count got %0d want %0d",
                                 got.unit_count, want.unit_count));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run got %0d want %0d",
                                 got.last_of_run, want.last_of_run));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #4 i_clk = ~i_clk;

    u8u16_in_if  in_ch ();
    u8u16_out_if out_ch ();

    utf8_to_utf16_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf16_scoreboard    sb;
    logic [7:0]         str_q[$];     // bytes of the string about to be sent
    bit                 quiet;        // no random idling on either side while set
    bit                 hold_req;     // asks the receiver for a long hold-off
    int                 live_bytes;   // bytes the decoder acted on
    int                 cycles;
    u8u16_pkg::t_result got_w;

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request so
    // the block fills up and has to push back on its input.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    out_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            out_ch.ready <= quiet || ($urandom_range(99) >= 22);
            @(posedge i_clk);
        end
    end

    // Output monitor: values read just after the edge are the ones the
    // block saw at that edge, so no ordering race with the drivers.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_w.unit          = out_ch.unit;
            got_w.is_terminator = out_ch.is_terminator;
            got_w.unit_count    = out_ch.unit_count;
            got_w.last_of_run   = out_ch.last_of_run;
            sb.check_word(got_w);
        end
    end

    // ------------------------------------------------------------------
    // Sender: pushes str_q out one word per handshake, end_of_string on
    // the final byte. Random idle cycles ahead of each word unless quiet.
    // ------------------------------------------------------------------
    task automatic send_string();
        int       n;
        logic [7:0] b;
        logic     eos;
        for (n = 0; n < str_q.size(); n++) begin
            b   = str_q[n];
            eos = (n == str_q.size() - 1);
            while (!quiet && $urandom_range(99) < 22) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid         <= 1'b1;
            in_ch.in_byte       <= b;
            in_ch.end_of_string <= eos;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            if (sb.note_byte(b, eos))
                live_bytes++;
        end
    endtask

    // Appends one character to str_q: mostly well-formed UTF-8 with random
    // content, sometimes with its last continuation dropped, sometimes noise.
    function automatic void add_char();
        int          pick;
        int          ncont;
        logic [31:0] v;
        logic [7:0]  base;
        pick = $urandom_range(99);
        if (pick < 35) begin
            str_q.push_back(8'($urandom_range(127)));
        end else if (pick < 88) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                ncont = 1; base = u8u16_pkg::LEAD_1; v = $urandom_range(32'h7FF);
            end else if (pick < 60) begin
                ncont = 2; base = u8u16_pkg::LEAD_2; v = $urandom_range(32'hFFFF);
            end else if (pick < 90) begin
                ncont = 3; base = u8u16_pkg::LEAD_3;
                pick = $urandom_range(99);
                if (pick < 70)
                    v = $urandom_range(32'h10FFFF);
                else if (pick < 85)
                    v = $urandom_range(32'h110010, 32'h10FFF0);  // around the top
                else
                    v = $urandom_range(32'h1FFFFF);
            end else if (pick < 95) begin
                ncont = 4; base = u8u16_pkg::LEAD_4; v = $urandom_range(32'h3FF_FFFF);
            end else begin
                ncont = 5; base = u8u16_pkg::LEAD_5; v = $urandom;
            end
            str_q.push_back(base + 8'(v >> (6 * ncont)));
            for (int i = ncont - 1; i >= 0; i--)
                str_q.push_back(u8u16_pkg::CONT_BASE | 8'((v >> (6 * i)) & 32'h3F));
            if ($urandom_range(99) < 8)
                void'(str_q.pop_back());                     // cut-short sequence
        end else if (pick < 94) begin
            // stray continuation
            str_q.push_back(u8u16_pkg::CONT_BASE | 8'($urandom_range(63)));
        end else begin
            str_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int nchars;
        int keep;
        bit pressed;

        sb                  = new();
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        live_bytes          = 0;
        pressed             = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ASCII extremes, 2-byte, 4-byte (surrogate pair), a 3-byte lead
        // broken by ASCII, a 2-byte lead broken by a zero on the last byte
        str_q = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80,
                  8'hE2, 8'h41, 8'hC3, 8'h00};
        send_string();
        // longest sequence, value far past the top: mutes, terminator only
        str_q = '{8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        send_string();
        // string ends inside a sequence
        str_q = '{8'hE2, 8'h82};
        send_string();
        // stray continuation, rest of string ignored
        str_q = '{8'h80, 8'h41};
        send_string();
        // lead byte alone as the whole string
        str_q = '{8'hC3};
        send_string();

        // Random strings. A stretch with no idling, then the long receiver
        // hold-off while the sender keeps offering back to back.
        while (live_bytes < RAND_BYTES) begin
            quiet = (live_bytes >= 40 && live_bytes < 80) ||
                    (live_bytes >= 100 && live_bytes < 130);
            if (!pressed && live_bytes >= 100) begin
                pressed  = 1'b1;
                hold_req = 1'b1;
            end
            str_q.delete();
            nchars = $urandom_range(6, 1);
            repeat (nchars) add_char();
            if (str_q.size() > 1 && $urandom_range(99) < 5) begin
                keep = $urandom_range(str_q.size() - 1, 1);  // early string end
                while (str_q.size() > keep) void'(str_q.pop_back());
            end
            send_string();
        end
        in_ch.valid <= 1'b0;
        quiet = 1'b0;

        // drain, then a few more cycles to catch stray words
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
